>>> sv/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg: shared types and constants of the page bitmap allocator
// Transaction structs, operation and status codes, sequencer states and the
// default geometry of the page bitmap.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

  localparam int PHYS_W      = 48;
  localparam int LIMIT_W     = 28;
  localparam int PAGE_ADDR_W = 27;

  localparam int PAGE_BYTES_DEF    = 4096;
  localparam int BITS_PER_WORD_DEF = 64;
  localparam int NUM_WORDS_DEF     = 512;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(134217728);

  typedef enum logic [1:0] {
    FN_ALLOC   = 2'd0,
    FN_FREE    = 2'd1,
    FN_RESERVE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_PAGE = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef struct packed {
    func_t             func;
    logic [PHYS_W-1:0] phys_addr;
    logic [PHYS_W-1:0] length;
  } req_t;

  typedef struct packed {
    status_t                status;
    logic [PAGE_ADDR_W-1:0] page_addr;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_SCAN,
    S_A_WR,
    S_F_CHK,
    S_R_PREP,
    S_R_SET,
    S_RD,
    S_WR
  } state_t;

endpackage

`default_nettype wire

>>> sv/pba_ram.sv
// ----------------------------------------------------------------------------
// pba_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 512,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/pba_word_unit.sv
// ----------------------------------------------------------------------------
// pba_word_unit: bitmap word update and search unit
// Sets or clears a run of pages inside one word and finds the lowest free
// page of the word. The lowest page of a word sits at its top bit.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_word_unit #(
  parameter int BITS_PER_WORD = 64,
  parameter int BIT_W         = $clog2(BITS_PER_WORD)
) (
  input  wire logic [BITS_PER_WORD-1:0] word_in,
  input  wire logic [BIT_W-1:0]         lo,
  input  wire logic [BIT_W-1:0]         hi,
  input  wire logic                     set,
  output logic      [BITS_PER_WORD-1:0] word_out,
  output logic                          free_found,
  output logic      [BIT_W-1:0]         free_idx
);

  logic [BITS_PER_WORD-1:0] mask;

  // page j of the word lives at bit BITS_PER_WORD-1-j
  always_comb begin
    for (int j = 0; j < BITS_PER_WORD; j++) begin
      mask[BITS_PER_WORD-1-j] = (BIT_W'(j) >= lo) && (BIT_W'(j) <= hi);
    end
  end

  assign word_out   = set ? (word_in | mask) : (word_in & ~mask);
  assign free_found = ~&word_in;

  // the highest clear bit is the lowest free page; later hits win
  always_comb begin
    free_idx = '0;
    for (int b = 0; b < BITS_PER_WORD; b++) begin
      if (!word_in[b]) begin
        free_idx = BIT_W'(BITS_PER_WORD - 1 - b);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator: used/free bitmap of physical pages
// Allocates, frees and reserves pages in a bitmap held in one RAM.
// ----------------------------------------------------------------------------
// Usage: present an operation on req and raise start; it is taken at a clock
// edge with start high and busy low. Busy stays high until the result is out.
// The result appears on rsp for exactly one cycle with done high; it cannot
// be held off. A new transaction can be taken at the edge that ends that cycle.
// cfg_we/cfg_wdata write the allocation limit (byte address), to be done only
// while the block is idle.
// Steps per operation (from accept to done), one bitmap word per RAM access:
//   alloc   : scan of words from the first non-full word hint, then the
//             write of the found word (no write when no page is free)
//   free    : range check, read, write (check only beyond the bitmap)
//   reserve : setup, then read then write of each word touched; setup
//             only when the range is empty or starts beyond the bitmap
//   unused  : finishes from idle with no RAM access
// The RAM (one read, one write port) sets these steps. After reset a
// clearing pass writes zeros to all NUM_WORDS words, one per cycle, with
// busy high; the limit returns to its reset value at once.
// PAGE_BYTES and BITS_PER_WORD are powers of two.
// ----------------------------------------------------------------------------
`default_nettype none

module page_bitmap_allocator #(
  parameter int PAGE_BYTES    = pba_pkg::PAGE_BYTES_DEF,
  parameter int BITS_PER_WORD = pba_pkg::BITS_PER_WORD_DEF,
  parameter int NUM_WORDS     = pba_pkg::NUM_WORDS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire pba_pkg::req_t                req,
  output logic                              busy,
  output logic                              done,
  output pba_pkg::rsp_t                     rsp,
  input  wire logic                         cfg_we,
  input  wire logic [pba_pkg::LIMIT_W-1:0]  cfg_wdata
);

  import pba_pkg::*;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int BIT_W      = $clog2(BITS_PER_WORD);
  localparam int WORD_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int PG_W       = WORD_W + BIT_W;
  localparam int TOTAL      = NUM_WORDS * BITS_PER_WORD;
  localparam int START_W    = PHYS_W - PAGE_SHIFT;
  localparam int CNT_W      = START_W + 1;
  localparam int END_W      = CNT_W + 1;
  localparam int A_W        = PG_W + PAGE_SHIFT;
  localparam int CMP_W      = (A_W > LIMIT_W) ? A_W : LIMIT_W;

  localparam logic [WORD_W-1:0] LAST_WORD = WORD_W'(NUM_WORDS - 1);

  state_t                   state, state_next;
  func_t                    op;
  logic [START_W-1:0]       st_pg;
  logic [CNT_W-1:0]         cnt;
  logic [END_W-1:0]         end_pg;
  logic [WORD_W-1:0]        cur_word, last_word, hint;
  logic [BIT_W-1:0]         lo_bit, last_bit, fnd_idx;
  logic [BITS_PER_WORD-1:0] held_word;
  logic                     rsv_err;
  logic [LIMIT_W-1:0]       limit;

  logic [WORD_W-1:0]        rd_addr;
  logic [BITS_PER_WORD-1:0] rd_data, wr_data;
  logic                     wr_en;

  logic [BITS_PER_WORD-1:0] unit_in, unit_out;
  logic [BIT_W-1:0]         unit_lo, unit_hi, free_idx;
  logic                     unit_set, free_found;

  logic                     fin;
  status_t                  fin_status;
  logic [PAGE_ADDR_W-1:0]   fin_addr;

  logic [PG_W-1:0]          fnd_page;
  logic [CMP_W-1:0]         alloc_addr;
  logic                     refuse;
  logic                     rsv_any, rsv_over;
  logic [END_W-1:0]         stop_pg, stop_m1;

  pba_ram #(
    .WIDTH (BITS_PER_WORD),
    .DEPTH (NUM_WORDS),
    .AW    (WORD_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (cur_word),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  pba_word_unit #(
    .BITS_PER_WORD (BITS_PER_WORD),
    .BIT_W         (BIT_W)
  ) u_word_unit (
    .word_in    (unit_in),
    .lo         (unit_lo),
    .hi         (unit_hi),
    .set        (unit_set),
    .word_out   (unit_out),
    .free_found (free_found),
    .free_idx   (free_idx)
  );

  assign fnd_page   = {cur_word, fnd_idx};
  assign alloc_addr = CMP_W'(fnd_page) << PAGE_SHIFT;
  assign refuse     = (fnd_page == '0) || (alloc_addr >= CMP_W'(limit));

  assign rsv_any  = (cnt != '0) && (st_pg < START_W'(TOTAL));
  assign rsv_over = (cnt != '0) && (end_pg > END_W'(TOTAL));
  assign stop_pg  = (end_pg > END_W'(TOTAL)) ? END_W'(TOTAL) : end_pg;
  assign stop_m1  = stop_pg - END_W'(1);

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_addr    = hint;
    wr_en      = 1'b0;
    wr_data    = unit_out;
    unit_in    = rd_data;
    unit_lo    = lo_bit;
    unit_hi    = (cur_word == last_word) ? last_bit : '1;
    unit_set   = (op != FN_FREE);
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_addr   = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '0;
        if (cur_word == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          unique case (req.func)
            FN_ALLOC:   state_next = S_A_SCAN;
            FN_FREE:    state_next = S_F_CHK;
            FN_RESERVE: state_next = S_R_PREP;
            default:    fin = 1'b1;
          endcase
        end
      end
      S_A_SCAN: begin
        // fetch the following word while this one is searched
        rd_addr = cur_word + WORD_W'(1);
        if (free_found) begin
          state_next = S_A_WR;
        end else if (cur_word == LAST_WORD) begin
          fin        = 1'b1;
          fin_status = ST_NO_PAGE;
          state_next = S_IDLE;
        end
      end
      S_A_WR: begin
        unit_in    = held_word;
        unit_lo    = fnd_idx;
        unit_hi    = fnd_idx;
        unit_set   = 1'b1;
        fin        = 1'b1;
        state_next = S_IDLE;
        if (refuse) begin
          fin_status = ST_NO_PAGE;
        end else begin
          wr_en    = 1'b1;
          fin_addr = PAGE_ADDR_W'(alloc_addr);
        end
      end
      S_F_CHK: begin
        if (st_pg >= START_W'(TOTAL)) begin
          fin        = 1'b1;
          fin_status = ST_RANGE;
          state_next = S_IDLE;
        end else begin
          state_next = S_RD;
        end
      end
      S_R_PREP: state_next = S_R_SET;
      S_R_SET: begin
        if (rsv_any) begin
          state_next = S_RD;
        end else begin
          fin        = 1'b1;
          fin_status = rsv_over ? ST_RANGE : ST_OK;
          state_next = S_IDLE;
        end
      end
      S_RD: begin
        rd_addr    = cur_word;
        state_next = S_WR;
      end
      S_WR: begin
        wr_en = 1'b1;
        if (cur_word == last_word) begin
          fin        = 1'b1;
          fin_status = rsv_err ? ST_RANGE : ST_OK;
          state_next = S_IDLE;
        end else begin
          state_next = S_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_word <= '0;
      hint     <= '0;
      limit    <= LIMIT_RESET;
      done     <= 1'b0;
    end else begin
      done <= fin;
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      unique case (state)
        S_CLEAR: cur_word <= cur_word + WORD_W'(1);
        S_IDLE: begin
          if (start) begin
            op       <= req.func;
            cur_word <= hint;
            st_pg    <= req.phys_addr[PHYS_W-1:PAGE_SHIFT];
            cnt      <= CNT_W'(req.length[PHYS_W-1:PAGE_SHIFT])
                      + CNT_W'(|req.length[PAGE_SHIFT-1:0]);
          end
        end
        S_A_SCAN: begin
          if (free_found) begin
            fnd_idx   <= free_idx;
            held_word <= rd_data;
          end else if (cur_word == LAST_WORD) begin
            hint <= cur_word;
          end else begin
            cur_word <= cur_word + WORD_W'(1);
          end
        end
        // every word below this one is full
        S_A_WR: hint <= cur_word;
        S_F_CHK: begin
          cur_word  <= st_pg[PG_W-1:BIT_W];
          last_word <= st_pg[PG_W-1:BIT_W];
          lo_bit    <= st_pg[BIT_W-1:0];
          last_bit  <= st_pg[BIT_W-1:0];
          rsv_err   <= 1'b0;
        end
        S_R_PREP: end_pg <= END_W'(st_pg) + END_W'(cnt);
        S_R_SET: begin
          cur_word  <= st_pg[PG_W-1:BIT_W];
          last_word <= stop_m1[PG_W-1:BIT_W];
          lo_bit    <= st_pg[BIT_W-1:0];
          last_bit  <= stop_m1[BIT_W-1:0];
          rsv_err   <= rsv_over;
        end
        S_WR: begin
          if (cur_word != last_word) begin
            cur_word <= cur_word + WORD_W'(1);
            lo_bit   <= '0;
          end
          // a freed page pulls the search hint back
          if (op == FN_FREE && cur_word < hint) begin
            hint <= cur_word;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      rsp.status    <= fin_status;
      rsp.page_addr <= fin_addr;
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status != ST_OK |-> rsp.page_addr == '0)
    else $error("failed transaction carries a page address");

  a_range_not_alloc: assert property (@(posedge clk) disable iff (rst)
    done && rsp.status == ST_RANGE |-> op != FN_ALLOC)
    else $error("range error reported for alloc");

  a_scan_from_hint: assert property (@(posedge clk) disable iff (rst)
    state == S_A_SCAN |-> cur_word >= hint)
    else $error("alloc scan below the search hint");

  a_clear_no_accept: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> busy && !done)
    else $error("clearing pass not holding off transactions");

endmodule

`default_nettype wire
